// File: sv/max_flow_widest_path_macros.svh
// Assertion macros for the max_flow_widest_path block.
// Used by files that check their own logic; needs clk and arst_n in scope.
`ifndef MAX_FLOW_WIDEST_PATH_MACROS_SVH
`define MAX_FLOW_WIDEST_PATH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFWP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFWP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mfwp_pkg.sv
// Shared constants for the max_flow_widest_path block.
// No dependencies.
package mfwp_pkg;
	localparam int MAX_NODES_DEF = 256;
	localparam int NODE_W        = 9;
	localparam int CAP_W         = 32;
	localparam int FLOW_W        = 48;
	localparam int IN_DATA_W     = 56;
	localparam int OUT_DATA_W    = 48;
	localparam logic [CAP_W-1:0]  WIDE_SOURCE = 32'hFFFF_FFFF;
	localparam logic [FLOW_W-1:0] FLOW_MAX    = 48'hFFFF_FFFF_FFFF;
endpackage

// File: sv/max_flow_widest_path.sv
// Maximum flow engine: edges are summed into a residual matrix held in RAM, and
// the flow from node 1 to node node_count is found by widest-path augmentation.
// Depends on mfwp_pkg, mfwp_ram and max_flow_widest_path_macros.svh.
//
// Timing: after reset, and again after every result, a clearing pass writes all
// MAX_NODES*MAX_NODES entries of the residual matrix (65536 at the default),
// during which no edge is taken. An edge is a read and then an accumulating
// write of the matrix RAM; an edge with a node out of range is dropped without
// a write. The edge marked last then starts the solve, which in each augmenting
// round resets the per-node search RAM, streams one matrix row through the
// shared compare unit for each node visited, and updates the found path hop by
// hop through the states AUG_P, AUG_F, AUG_FW, AUG_R and AUG_RW. The result
// waits in an output register. node_count is taken only while the block is
// clearing or idle with no edge offered.
`include "max_flow_widest_path_macros.svh"

module max_flow_widest_path #(
	parameter int MAX_NODES = mfwp_pkg::MAX_NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data,        // node_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,    // from_node[8:0], to_node[17:9], edge_capacity[49:18]
	input  logic        s_axis_tlast,    // last_edge
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,    // total_flow[47:0]
	output logic        m_axis_tuser     // bad_edge_seen
);
	localparam int NW     = $clog2(MAX_NODES);
	localparam int CW     = $clog2(MAX_NODES + 1);
	localparam int MDEPTH = MAX_NODES * MAX_NODES;
	localparam int AW     = $clog2(MDEPTH);
	localparam int SW     = mfwp_pkg::CAP_W + NW + 1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_LOAD_WR, ST_INIT, ST_RELAX,
		ST_AUG_P, ST_AUG_F, ST_AUG_FW, ST_AUG_R, ST_AUG_RW, ST_DONE
	} state_t;

	state_t            state_q;
	logic [8:0]        node_count_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     eaddr_q;
	logic [31:0]       ecap_q;
	logic              elast_q;
	logic              bad_q;
	logic [47:0]       flow_q;
	logic [CW-1:0]     j_q;
	logic              v_s1;
	logic [NW-1:0]     j_s1;
	logic [NW-1:0]     sel_q;
	logic [31:0]       best_q;
	logic [NW-1:0]     cand_q;
	logic [31:0]       cand_w_q;
	logic              cand_ok_q;
	logic [31:0]       pw_q;
	logic [NW-1:0]     cur_q;
	logic [NW-1:0]     p_q;
	logic [CW-1:0]     steps_q;
	logic              out_valid_q;
	logic [47:0]       out_flow_q;
	logic              out_bad_q;

	function automatic logic [AW-1:0] maddr(input logic [NW-1:0] r, input logic [NW-1:0] c);
		logic [31:0] t;
		t = 32'(r) * 32'(MAX_NODES) + 32'(c);
		return t[AW-1:0];
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// effective node count
	logic [31:0]   cnt_ext;
	logic [31:0]   n_full;
	logic [CW-1:0] n;
	logic [NW-1:0] sink;
	assign cnt_ext = {23'b0, node_count_q};
	assign n_full  = (cnt_ext < 32'd2) ? 32'd2 :
		(cnt_ext > 32'(MAX_NODES)) ? 32'(MAX_NODES) : cnt_ext;
	assign n    = n_full[CW-1:0];
	assign sink = NW'(n_full - 32'd1);

	// input edge fields
	logic [8:0]    e_u, e_v;
	logic [31:0]   e_cap;
	logic          e_bad;
	logic [AW-1:0] e_addr;
	assign e_u   = s_axis_tdata[8:0];
	assign e_v   = s_axis_tdata[17:9];
	assign e_cap = s_axis_tdata[49:18];
	assign e_bad = (e_u == 9'd0) || ({23'b0, e_u} > n_full) ||
		(e_v == 9'd0) || ({23'b0, e_v} > n_full);
	assign e_addr = maddr(NW'(e_u - 9'd1), NW'(e_v - 9'd1));

	logic in_xfer;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	// hold off a node count change while a graph is being solved
	assign cfg_ready     = (state_q == ST_CLEAR) || ((state_q == ST_IDLE) && !s_axis_tvalid);

	// RAMs
	logic          m_we;
	logic [AW-1:0] m_waddr, m_raddr;
	logic [31:0]   m_wdata, m_rdata;
	logic          s_we;
	logic [NW-1:0] s_waddr, s_raddr;
	logic [SW-1:0] s_wdata, s_rdata;

	mfwp_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_matrix (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	mfwp_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_search (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	// relaxation of one entry of the selected row
	logic [31:0]   r_sw, r_w, r_nw;
	logic [NW-1:0] r_sp, r_np;
	logic          r_sv, r_nv, r_upd, r_better;
	logic          fc_ok;
	logic [NW-1:0] fc_idx;
	logic [31:0]   fc_w;
	logic          row_end;
	always_comb begin
		r_sw     = s_rdata[31:0];
		r_sp     = s_rdata[NW+31:32];
		r_sv     = s_rdata[SW-1];
		r_w      = (m_rdata < best_q) ? m_rdata : best_q;
		r_upd    = r_sw < r_w;
		r_nw     = r_upd ? r_w : r_sw;
		r_np     = r_upd ? sel_q : r_sp;
		r_nv     = r_sv || (j_s1 == sel_q);
		r_better = !r_nv && (r_nw > cand_w_q);
		fc_ok    = cand_ok_q || r_better;
		fc_idx   = r_better ? j_s1 : cand_q;
		fc_w     = r_better ? r_nw : cand_w_q;
		row_end  = v_s1 && (j_s1 == sink);
	end

	logic [48:0] flow_add;
	logic [31:0] fwd_new;
	assign flow_add = {1'b0, flow_q} + {17'b0, fc_w};
	assign fwd_new  = (m_rdata > pw_q) ? (m_rdata - pw_q) : 32'd0;

	always_comb begin
		m_we    = 1'b0;
		m_waddr = clr_q;
		m_wdata = 32'd0;
		m_raddr = e_addr;
		s_we    = 1'b0;
		s_waddr = NW'(j_q);
		s_wdata = {1'b0, {NW{1'b0}}, 32'd0};
		s_raddr = NW'(j_q);
		case (state_q)
			ST_CLEAR: begin
				m_we = 1'b1;
			end
			ST_LOAD_WR: begin
				m_we    = 1'b1;
				m_waddr = eaddr_q;
				m_wdata = sat_add(m_rdata, ecap_q);
			end
			ST_INIT: begin
				s_we    = 1'b1;
				s_wdata = {1'b0, {NW{1'b0}},
					(j_q == '0) ? mfwp_pkg::WIDE_SOURCE : 32'd0};
			end
			ST_RELAX: begin
				m_raddr = maddr(sel_q, NW'(j_q));
				s_we    = v_s1;
				s_waddr = j_s1;
				s_wdata = {r_nv, r_np, r_nw};
			end
			ST_AUG_P: begin
				s_raddr = cur_q;
			end
			ST_AUG_F: begin
				m_raddr = maddr(s_rdata[NW+31:32], cur_q);
			end
			ST_AUG_FW: begin
				m_we    = 1'b1;
				m_waddr = maddr(p_q, cur_q);
				m_wdata = fwd_new;
			end
			ST_AUG_R: begin
				m_raddr = maddr(cur_q, p_q);
			end
			ST_AUG_RW: begin
				m_we    = 1'b1;
				m_waddr = maddr(cur_q, p_q);
				m_wdata = sat_add(m_rdata, pw_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			node_count_q <= 9'd256;
			clr_q        <= '0;
			bad_q        <= 1'b0;
			flow_q       <= '0;
			v_s1         <= 1'b0;
			out_valid_q  <= 1'b0;
			elast_q      <= 1'b0;
			j_q          <= '0;
			cand_ok_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MDEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						eaddr_q <= e_addr;
						ecap_q  <= e_cap;
						elast_q <= s_axis_tlast;
						j_q     <= '0;
						if (e_bad) begin
							bad_q   <= 1'b1;
							state_q <= s_axis_tlast ? ST_INIT : ST_IDLE;
						end else begin
							state_q <= ST_LOAD_WR;
						end
					end
				end
				ST_LOAD_WR: begin
					state_q <= elast_q ? ST_INIT : ST_IDLE;
				end
				ST_INIT: begin
					// reset the per-node search entries, then start from the source
					if (j_q == n - 1'b1) begin
						j_q       <= '0;
						sel_q     <= '0;
						best_q    <= mfwp_pkg::WIDE_SOURCE;
						cand_ok_q <= 1'b0;
						cand_w_q  <= '0;
						v_s1      <= 1'b0;
						state_q   <= ST_RELAX;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_RELAX: begin
					if (row_end) begin
						v_s1      <= 1'b0;
						j_q       <= '0;
						cand_ok_q <= 1'b0;
						cand_w_q  <= '0;
						if (!fc_ok) begin
							state_q <= ST_DONE;
						end else if (fc_idx == sink) begin
							// path found: account for it and walk it back
							pw_q    <= fc_w;
							flow_q  <= flow_add[48] ? mfwp_pkg::FLOW_MAX : flow_add[47:0];
							cur_q   <= sink;
							steps_q <= '0;
							state_q <= ST_AUG_P;
						end else begin
							sel_q  <= fc_idx;
							best_q <= fc_w;
						end
					end else begin
						if (j_q < n) begin
							v_s1 <= 1'b1;
							j_s1 <= NW'(j_q);
							j_q  <= j_q + 1'b1;
						end else begin
							v_s1 <= 1'b0;
						end
						if (v_s1 && r_better) begin
							cand_ok_q <= 1'b1;
							cand_q    <= j_s1;
							cand_w_q  <= r_nw;
						end
					end
				end
				ST_AUG_P: begin
					state_q <= ST_AUG_F;
				end
				ST_AUG_F: begin
					p_q     <= s_rdata[NW+31:32];
					state_q <= ST_AUG_FW;
				end
				ST_AUG_FW: begin
					state_q <= ST_AUG_R;
				end
				ST_AUG_R: begin
					state_q <= ST_AUG_RW;
				end
				ST_AUG_RW: begin
					cur_q   <= p_q;
					steps_q <= steps_q + 1'b1;
					j_q     <= '0;
					if ((p_q != '0) && ((steps_q + 1'b1) < n)) begin
						state_q <= ST_AUG_P;
					end else begin
						state_q <= ST_INIT;
					end
				end
				ST_DONE: begin
					// hold until the previous result has been taken
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_flow_q  <= flow_q;
						out_bad_q   <= bad_q;
						flow_q      <= '0;
						bad_q       <= 1'b0;
						clr_q       <= '0;
						state_q     <= ST_CLEAR;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_flow_q;
	assign m_axis_tuser  = out_bad_q;

	`MFWP_ASSERT_NOW(a_relax_in_range, v_s1, {1'b0, j_s1} < {1'b0, n}, "row scan index past node count")
	`MFWP_ASSERT_NOW(a_sel_in_range, state_q == ST_RELAX, {1'b0, sel_q} < {1'b0, n}, "selected node out of range")
	`MFWP_ASSERT_NOW(a_result_from_done, $rose(out_valid_q), $past(state_q == ST_DONE), "result raised outside done")
	`MFWP_ASSERT_NEXT(a_edge_load, in_xfer && !e_bad, state_q == ST_LOAD_WR, "accepted edge not written")
endmodule

// File: sv/mfwp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfwp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
